>>> src/brc_pkg.sv
package brc_pkg;

    // Field and datapath widths.
    localparam int PITCH_W  = 17;
    localparam int GYRO_W   = 16;
    localparam int YAW_W    = 9;
    localparam int ENC_W    = 16;
    localparam int TURN_W   = 16;
    localparam int DRIVE_W  = 14;
    localparam int GAIN_W   = 32;
    localparam int TGT_W    = 16;

    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 32;

    // Multiplier operands and product.
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 26;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // A product shifted down by at least 16 bits.
    localparam int TERM_W = PROD_W - 16;
    // Accumulators for the mixed terms and their final sum.
    localparam int ACC_W  = TERM_W + 4;
    localparam int SUM_W  = ACC_W + 1;

    // Speed filter: accumulator of raw products, and the filtered value in Q8.
    localparam int FACC_W = 42;
    localparam int FILT_W = 24;

    // Speed integral in Q8; wide enough for every allowed clamp bound.
    localparam int INTEG_W = 26;
    localparam int ISUM_W  = INTEG_W + 1;

    localparam int FRAC_SCALE = 256;

    // Microcode step counter.
    localparam int STEP_W = 4;

    // Arithmetic constants.
    localparam logic signed [MUL_A_W-1:0] FILT_NEW = 32'sd19661;
    localparam logic signed [MUL_A_W-1:0] FILT_OLD = 32'sd45875;
    localparam logic signed [GYRO_W:0]    GYRO_OFS = 17'sd22;
    localparam logic [TURN_W-1:0]         CMD_REMAP_MIN = 16'd100;
    localparam logic signed [TURN_W:0]    CMD_REMAP_OFS = 17'sd200;
    localparam logic [PROD_W-1:0]         BIAS_SH16 = PROD_W'(16'hFFFF);
    localparam logic [PROD_W-1:0]         BIAS_SH24 = PROD_W'(24'hFF_FFFF);
    localparam logic [FACC_W-1:0]         BIAS_FILT = FACC_W'(16'hFFFF);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_TRIM   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPRIGHT_KP   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UPRIGHT_KD   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_KP     = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_KI     = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEER_KP     = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEER_KD     = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_TARGET = 8'd7;

    // Default parameter values.
    localparam int DEF_DRIVE_LIMIT      = 7000;
    localparam int DEF_INTEGRAL_MAX     = 300;
    localparam int DEF_INTEGRAL_MIN_MAG = 200;

    typedef struct packed {
        logic signed [PITCH_W-1:0] pitch_trim;
        logic signed [GAIN_W-1:0]  upright_kp;
        logic signed [GAIN_W-1:0]  upright_kd;
        logic signed [GAIN_W-1:0]  speed_kp;
        logic signed [GAIN_W-1:0]  speed_ki;
        logic signed [GAIN_W-1:0]  steer_kp;
        logic signed [GAIN_W-1:0]  steer_kd;
        logic signed [TGT_W-1:0]   speed_target;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        pitch_trim:   -17'sd538,
        upright_kp:   -32'sd23592960,
        upright_kd:   -32'sd78643,
        speed_kp:     32'sd2424832,
        speed_ki:     32'sd12124,
        steer_kp:     32'sd983040,
        steer_kd:     32'sd11796,
        speed_target: 16'sd10
    };

    // Sequencing of the step counter.
    typedef enum logic [1:0] {
        SEQ_WAIT,
        SEQ_NEXT,
        SEQ_DONE
    } t_seq_op;

    // Operand pair presented to the shared multiplier.
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_UP_KP,
        MUL_UP_KD,
        MUL_FILT_NEW,
        MUL_FILT_OLD,
        MUL_SPD_KP,
        MUL_SPD_KI,
        MUL_STR_KP,
        MUL_STR_KD
    } t_mul_sel;

    // Use of the product registered in the previous step.
    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_BASE_ADD,
        ACC_BASE_SUB,
        ACC_STEER_SUB,
        ACC_FILT_LOAD,
        ACC_FILT_ADD
    } t_acc_op;

    // State updates beside the accumulators.
    typedef enum logic [1:0] {
        MISC_NONE,
        MISC_FILT,
        MISC_INTEG
    } t_misc_op;

    typedef struct packed {
        t_seq_op  seq;
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        logic     shift24;
        t_misc_op misc_op;
    } t_uword;

    typedef struct packed {
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        logic     shift24;
        t_misc_op misc_op;
        logic     capture;
        logic     out_load;
    } t_ctrl;

    // Control program. Each product is used in the step after the one that selects its operands.
    function automatic t_uword ucode_word(input logic [STEP_W-1:0] step);
        t_uword w;
        w = '{seq: SEQ_NEXT, mul_sel: MUL_NONE, acc_op: ACC_NONE, shift24: 1'b0,
              misc_op: MISC_NONE};
        case (step)
            4'd0: w.seq = SEQ_WAIT;
            4'd1: w.mul_sel = MUL_UP_KP;
            4'd2: begin
                w.mul_sel = MUL_UP_KD;
                w.acc_op  = ACC_BASE_ADD;
                w.shift24 = 1'b1;
            end
            4'd3: begin
                w.mul_sel = MUL_FILT_NEW;
                w.acc_op  = ACC_BASE_ADD;
            end
            4'd4: begin
                w.mul_sel = MUL_FILT_OLD;
                w.acc_op  = ACC_FILT_LOAD;
            end
            4'd5: begin
                w.mul_sel = MUL_STR_KP;
                w.acc_op  = ACC_FILT_ADD;
            end
            4'd6: begin
                w.mul_sel = MUL_STR_KD;
                w.acc_op  = ACC_STEER_SUB;
                w.misc_op = MISC_FILT;
            end
            4'd7: begin
                w.mul_sel = MUL_SPD_KP;
                w.acc_op  = ACC_STEER_SUB;
                w.misc_op = MISC_INTEG;
            end
            4'd8: begin
                w.mul_sel = MUL_SPD_KI;
                w.acc_op  = ACC_BASE_SUB;
                w.shift24 = 1'b1;
            end
            4'd9: begin
                w.acc_op  = ACC_BASE_SUB;
                w.shift24 = 1'b1;
            end
            4'd10: w.seq = SEQ_DONE;
            default: w.seq = SEQ_WAIT;
        endcase
        return w;
    endfunction

endpackage

>>> src/brc_sequencer.sv
module brc_sequencer
    import brc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_out_ready,
    output logic  o_out_valid,
    output t_ctrl o_ctrl
);

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic              r_out_valid;
    logic              n_out_valid;
    t_uword            w_word;
    logic              w_accept;
    logic              w_stall;

    // Control word of the current step.
    always_comb begin
        w_word = ucode_word(r_step);
    end

    // Input is taken only at the wait step; the last step holds while the result slot is full.
    assign o_in_ready = (w_word.seq == SEQ_WAIT);
    assign w_accept   = o_in_ready && i_in_valid;
    assign w_stall    = (w_word.seq == SEQ_DONE) && r_out_valid && !i_out_ready;

    // Step counter with its conditional jumps.
    always_comb begin
        case (w_word.seq)
            SEQ_WAIT: n_step = w_accept ? STEP_W'(1) : '0;
            SEQ_NEXT: n_step = STEP_W'(r_step + 1'b1);
            SEQ_DONE: n_step = w_stall ? r_step : '0;
            default:  n_step = '0;
        endcase
    end

    // Result slot occupancy.
    always_comb begin
        if ((w_word.seq == SEQ_DONE) && !w_stall) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath controls.
    always_comb begin
        o_ctrl.mul_sel  = w_word.mul_sel;
        o_ctrl.acc_op   = w_word.acc_op;
        o_ctrl.shift24  = w_word.shift24;
        o_ctrl.misc_op  = w_word.misc_op;
        o_ctrl.capture  = w_accept;
        o_ctrl.out_load = (w_word.seq == SEQ_DONE) && !w_stall;
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> src/brc_datapath.sv
module brc_datapath
    import brc_pkg::*;
#(
    parameter int DRIVE_LIMIT      = DEF_DRIVE_LIMIT,
    parameter int INTEGRAL_MAX     = DEF_INTEGRAL_MAX,
    parameter int INTEGRAL_MIN_MAG = DEF_INTEGRAL_MIN_MAG
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_ctrl                     i_ctrl,
    input  t_cfg                      i_cfg,
    input  logic signed [PITCH_W-1:0] i_pitch,
    input  logic signed [GYRO_W-1:0]  i_gyro_y,
    input  logic signed [YAW_W-1:0]   i_yaw_deg,
    input  logic signed [ENC_W-1:0]   i_wheel_count_l,
    input  logic signed [ENC_W-1:0]   i_wheel_count_r,
    input  logic [TURN_W-1:0]         i_turn_command,
    input  logic                      i_enable,
    output logic signed [DRIVE_W-1:0] o_left_drive,
    output logic signed [DRIVE_W-1:0] o_right_drive
);

    localparam logic signed [ISUM_W-1:0] INTEG_HI = ISUM_W'(INTEGRAL_MAX * FRAC_SCALE);
    localparam logic signed [ISUM_W-1:0] INTEG_LO = ISUM_W'(-(INTEGRAL_MIN_MAG * FRAC_SCALE));
    localparam logic signed [SUM_W-1:0]  DRV_HI   = SUM_W'(DRIVE_LIMIT);
    localparam logic signed [SUM_W-1:0]  DRV_LO   = SUM_W'(-DRIVE_LIMIT);

    // Captured item.
    logic signed [PITCH_W-1:0] r_pitch;
    logic signed [GYRO_W-1:0]  r_gyro_y;
    logic signed [YAW_W-1:0]   r_yaw_deg;
    logic signed [ENC_W-1:0]   r_enc_l;
    logic signed [ENC_W-1:0]   r_enc_r;
    logic [TURN_W-1:0]         r_turn;
    logic                      r_enable;

    // Multiplier and accumulators.
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_base;
    logic signed [ACC_W-1:0]   r_steer;
    logic signed [FACC_W-1:0]  r_facc;
    logic signed [FILT_W-1:0]  r_filt;
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [DRIVE_W-1:0] r_left;
    logic signed [DRIVE_W-1:0] r_right;

    logic signed [PITCH_W:0]   w_pitch_err;
    logic signed [GYRO_W:0]    w_gyro_ofs;
    logic signed [ENC_W:0]     w_enc_sum;
    logic signed [FILT_W-1:0]  w_mean;
    logic signed [TURN_W:0]    w_cmd_raw;
    logic signed [TURN_W:0]    w_cmd;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0]  w_bias;
    logic signed [PROD_W-1:0]  w_rnd;
    logic signed [PROD_W-1:0]  w_shifted;
    logic signed [TERM_W-1:0]  w_term;
    logic signed [FACC_W-1:0]  w_raw;
    logic signed [FACC_W-1:0]  w_facc_rnd;
    logic signed [FACC_W-1:0]  w_facc_sh;
    logic signed [FILT_W-1:0]  w_tgt_q8;
    logic signed [ISUM_W-1:0]  w_isum;
    logic signed [ISUM_W-1:0]  w_iclamp;
    logic signed [SUM_W-1:0]   w_left_sum;
    logic signed [SUM_W-1:0]   w_right_sum;

    // Clamp a mixed drive value to the limit and keep the port bits.
    function automatic logic [DRIVE_W-1:0] sat_drive(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        if (v > DRV_HI) begin
            c = DRV_HI;
        end else if (v < DRV_LO) begin
            c = DRV_LO;
        end else begin
            c = v;
        end
        return c[DRIVE_W-1:0];
    endfunction

    // Capture the item when it is accepted.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_pitch   <= i_pitch;
            r_gyro_y  <= i_gyro_y;
            r_yaw_deg <= i_yaw_deg;
            r_enc_l   <= i_wheel_count_l;
            r_enc_r   <= i_wheel_count_r;
            r_turn    <= i_turn_command;
            r_enable  <= i_enable;
        end
    end

    // Operand preparation: offsets, wheel mean in Q8 and command remap.
    always_comb begin
        w_pitch_err = (PITCH_W + 1)'(r_pitch) - (PITCH_W + 1)'(i_cfg.pitch_trim);
        w_gyro_ofs  = (GYRO_W + 1)'(r_gyro_y) + GYRO_OFS;
        w_enc_sum   = (ENC_W + 1)'(r_enc_l) + (ENC_W + 1)'(r_enc_r);
        w_mean      = {w_enc_sum, 7'd0};
        w_cmd_raw   = signed'({1'b0, r_turn});
        w_cmd       = (r_turn >= CMD_REMAP_MIN) ? (w_cmd_raw - CMD_REMAP_OFS) : w_cmd_raw;
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        case (i_ctrl.mul_sel)
            MUL_UP_KP: begin
                w_mul_a = i_cfg.upright_kp;
                w_mul_b = MUL_B_W'(w_pitch_err);
            end
            MUL_UP_KD: begin
                w_mul_a = i_cfg.upright_kd;
                w_mul_b = MUL_B_W'(w_gyro_ofs);
            end
            MUL_FILT_NEW: begin
                w_mul_a = FILT_NEW;
                w_mul_b = MUL_B_W'(w_mean);
            end
            MUL_FILT_OLD: begin
                w_mul_a = FILT_OLD;
                w_mul_b = MUL_B_W'(r_filt);
            end
            MUL_SPD_KP: begin
                w_mul_a = i_cfg.speed_kp;
                w_mul_b = MUL_B_W'(r_filt);
            end
            MUL_SPD_KI: begin
                w_mul_a = i_cfg.speed_ki;
                w_mul_b = MUL_B_W'(r_integ);
            end
            MUL_STR_KP: begin
                w_mul_a = i_cfg.steer_kp;
                w_mul_b = MUL_B_W'(w_cmd);
            end
            MUL_STR_KD: begin
                w_mul_a = i_cfg.steer_kd;
                w_mul_b = MUL_B_W'(r_yaw_deg);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
    end

    // Product shifted down with truncation toward zero.
    always_comb begin
        if (r_prod[PROD_W-1]) begin
            w_bias = i_ctrl.shift24 ? signed'(BIAS_SH24) : signed'(BIAS_SH16);
        end else begin
            w_bias = '0;
        end
        w_rnd     = r_prod + w_bias;
        w_shifted = i_ctrl.shift24 ? (w_rnd >>> 24) : (w_rnd >>> 16);
        w_term    = w_shifted[TERM_W-1:0];
        w_raw     = r_prod[FACC_W-1:0];
    end

    // Term accumulators and the filter's raw sum.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_base  <= '0;
            r_steer <= '0;
        end else begin
            case (i_ctrl.acc_op)
                ACC_BASE_ADD:  r_base  <= r_base + ACC_W'(w_term);
                ACC_BASE_SUB:  r_base  <= r_base - ACC_W'(w_term);
                ACC_STEER_SUB: r_steer <= r_steer - ACC_W'(w_term);
                ACC_FILT_LOAD: r_facc  <= w_raw;
                ACC_FILT_ADD:  r_facc  <= r_facc + w_raw;
                default: ;
            endcase
        end
    end

    // Filter output in Q8 and the clamped speed integral.
    always_comb begin
        w_facc_rnd = r_facc + (r_facc[FACC_W-1] ? signed'(BIAS_FILT) : FACC_W'(0));
        w_facc_sh  = w_facc_rnd >>> 16;
        w_tgt_q8   = {i_cfg.speed_target, 8'd0};
        w_isum     = ISUM_W'(r_integ) + ISUM_W'(r_filt) - ISUM_W'(w_tgt_q8);
        if (w_isum > INTEG_HI) begin
            w_iclamp = INTEG_HI;
        end else if (w_isum < INTEG_LO) begin
            w_iclamp = INTEG_LO;
        end else begin
            w_iclamp = w_isum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt  <= '0;
            r_integ <= '0;
        end else begin
            case (i_ctrl.misc_op)
                MISC_FILT:  r_filt  <= w_facc_sh[FILT_W-1:0];
                MISC_INTEG: r_integ <= r_enable ? INTEG_W'(w_iclamp) : '0;
                default: ;
            endcase
        end
    end

    // Wheel mix and saturation into the result register.
    always_comb begin
        w_left_sum  = SUM_W'(r_base) + SUM_W'(r_steer);
        w_right_sum = SUM_W'(r_base) - SUM_W'(r_steer);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.out_load) begin
            r_left  <= sat_drive(w_left_sum);
            r_right <= sat_drive(w_right_sum);
        end
    end

    assign o_left_drive  = r_left;
    assign o_right_drive = r_right;

endmodule

>>> src/balance_robot_cascade_controller.sv
// Channel  | Direction | Handshake                    | Content
// ---------+-----------+------------------------------+------------------------------------
// s_axis   | in        | s_axis_tvalid/s_axis_tready  | one control tick (sensors, command)
// m_axis   | out       | m_axis_tvalid/m_axis_tready  | left and right wheel drive
// cfg      | in        | i_cfg_valid/o_cfg_ready      | gain, trim and target registers
//
// A tick is accepted when the sequencer sits at its wait step; its result is loaded into the output
// register at the last step, and the next tick is taken only once the program is back at its wait
// step. The microcode steps share one 32x26 multiplier.
// Reset loads the register defaults and clears the speed filter and the speed integral.
// A result waiting for m_axis_tready does not block the next tick; the program holds at its
// last step only if the previous result has still not been taken.
module balance_robot_cascade_controller
    import brc_pkg::*;
#(
    parameter int DRIVE_LIMIT      = DEF_DRIVE_LIMIT,
    parameter int INTEGRAL_MAX     = DEF_INTEGRAL_MAX,
    parameter int INTEGRAL_MIN_MAG = DEF_INTEGRAL_MIN_MAG
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // pitch[16:0], gyro_y[32:17], yaw_deg[41:33], wheel_count_l[57:42],
    // wheel_count_r[73:58], turn_command[89:74], zero fill [95:90]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // enable[0]
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // left_drive[13:0], right_drive[27:14], zero fill [31:28]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [GAIN_W-1:0]      i_cfg_data
);

    t_cfg                      r_cfg;
    t_ctrl                     w_ctrl;
    logic signed [DRIVE_W-1:0] w_left_drive;
    logic signed [DRIVE_W-1:0] w_right_drive;

    // Register writes; an index beyond the register list is dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_PITCH_TRIM:   r_cfg.pitch_trim   <= i_cfg_data[PITCH_W-1:0];
                REG_UPRIGHT_KP:   r_cfg.upright_kp   <= i_cfg_data;
                REG_UPRIGHT_KD:   r_cfg.upright_kd   <= i_cfg_data;
                REG_SPEED_KP:     r_cfg.speed_kp     <= i_cfg_data;
                REG_SPEED_KI:     r_cfg.speed_ki     <= i_cfg_data;
                REG_STEER_KP:     r_cfg.steer_kp     <= i_cfg_data;
                REG_STEER_KD:     r_cfg.steer_kd     <= i_cfg_data;
                REG_SPEED_TARGET: r_cfg.speed_target <= i_cfg_data[TGT_W-1:0];
                default: ;
            endcase
        end
    end

    brc_sequencer u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_ctrl      (w_ctrl)
    );

    brc_datapath #(
        .DRIVE_LIMIT      (DRIVE_LIMIT),
        .INTEGRAL_MAX     (INTEGRAL_MAX),
        .INTEGRAL_MIN_MAG (INTEGRAL_MIN_MAG)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (w_ctrl),
        .i_cfg           (r_cfg),
        .i_pitch         (s_axis_tdata[16:0]),
        .i_gyro_y        (s_axis_tdata[32:17]),
        .i_yaw_deg       (s_axis_tdata[41:33]),
        .i_wheel_count_l (s_axis_tdata[57:42]),
        .i_wheel_count_r (s_axis_tdata[73:58]),
        .i_turn_command  (s_axis_tdata[89:74]),
        .i_enable        (s_axis_tuser),
        .o_left_drive    (w_left_drive),
        .o_right_drive   (w_right_drive)
    );

    assign m_axis_tdata = {4'd0, w_right_drive, w_left_drive};

    // Once a tick is taken, the sequencer is busy with it in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input still ready right after a tick was taken");

    // A new result appears only as the program returns to its wait step.
    a_result_at_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result raised outside the end of the program");

    // The result register is never loaded over a result that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("pending result overwritten");

endmodule
